### sv/fsd_pkg.sv
// fsd_pkg: shared types, constants and arithmetic helpers of the grayscale
// floyd-steinberg dither block
// depends on nothing; imported by every module of the block
`default_nettype none

package fsd_pkg;

    localparam int MAX_LINE_WIDTH = 2048;
    localparam int LINE_AW        = $clog2(MAX_LINE_WIDTH);
    localparam int FILL_W         = LINE_AW + 1;
    localparam int WCMP_W         = (LINE_AW + 1 > 12) ? LINE_AW + 1 : 12;

    localparam int ERR_W  = 20;
    localparam int V_W    = ERR_W + 3;
    localparam int PROD_W = ERR_W + 4;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD_LEVEL = 2'd2;

    localparam logic [11:0] IMAGE_WIDTH_RST     = 12'd640;
    localparam logic [11:0] IMAGE_HEIGHT_RST    = 12'd480;
    localparam logic [7:0]  THRESHOLD_LEVEL_RST = 8'd127;

    localparam logic [2:0] K_RIGHT       = 3'd7;
    localparam logic [2:0] K_BELOW_LEFT  = 3'd3;
    localparam logic [2:0] K_BELOW       = 3'd5;
    localparam logic [2:0] K_BELOW_RIGHT = 3'd1;

    localparam logic [7:0] LEVEL_WHITE = 8'd255;
    localparam logic [7:0] LEVEL_BLACK = 8'd0;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic [11:0] image_width;
        logic [11:0] image_height;
        logic [7:0]  threshold_level;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         pixel;
        logic [LINE_AW-1:0] col;
        logic               last_col;
        logic               last_row;
    } pix_item_t;

    typedef struct packed {
        logic               en;
        logic [LINE_AW-1:0] addr;
        err_t               data;
    } line_wr_t;

    // saturate a wide sum into the error range
    function automatic err_t sat_f(input logic signed [V_W-1:0] x);
        logic signed [V_W-1:0] hi;
        logic signed [V_W-1:0] lo;
        hi = V_W'((2 ** (ERR_W - 1)) - 1);
        lo = -V_W'(2 ** (ERR_W - 1));
        if (x > hi)
        begin
            return ERR_W'(hi);
        end
        else if (x < lo)
        begin
            return ERR_W'(lo);
        end
        return ERR_W'(x);
    endfunction

    // err*k/16 rounded to nearest, halves towards +inf
    function automatic err_t share_f(input err_t e, input logic [2:0] k);
        logic signed [PROD_W-1:0] num;
        num = PROD_W'(e) * $signed({{(PROD_W-3){1'b0}}, k}) + PROD_W'(8);
        return ERR_W'(num >>> 4);
    endfunction

endpackage

`default_nettype wire

### sv/fsd_cfg.sv
// fsd_cfg: apb-style configuration registers (width, height, threshold)
// depends on fsd_pkg
`default_nettype none

module fsd_cfg
    import fsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_IMAGE_WIDTH:     cfg_next.image_width     = pwdata[11:0];
                REG_IMAGE_HEIGHT:    cfg_next.image_height    = pwdata[11:0];
                REG_THRESHOLD_LEVEL: cfg_next.threshold_level = pwdata[7:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_IMAGE_WIDTH:     prdata = {20'd0, cfg_reg.image_width};
            REG_IMAGE_HEIGHT:    prdata = {20'd0, cfg_reg.image_height};
            REG_THRESHOLD_LEVEL: prdata = {24'd0, cfg_reg.threshold_level};
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_width     <= IMAGE_WIDTH_RST;
            cfg_reg.image_height    <= IMAGE_HEIGHT_RST;
            cfg_reg.threshold_level <= THRESHOLD_LEVEL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### sv/fsd_line_mem.sv
// fsd_line_mem: error line buffer, one synchronous read and one write port,
// same-edge write forwarding and a fill mark standing in for a reset clear
// depends on fsd_pkg
`default_nettype none

module fsd_line_mem
    import fsd_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rd_en,
    input  wire logic [LINE_AW-1:0] rd_addr,
    input  wire line_wr_t           wr,
    output err_t                    rd_data
);

    err_t              err_mem [MAX_LINE_WIDTH];
    err_t              rd_q_reg;
    err_t              fwd_reg;
    logic              hit_reg;
    logic              hit_next;
    logic              zero_reg;
    logic              zero_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] wr_top;

    // entries at or above the fill mark were never written and read as zero
    always_comb
    begin
        wr_top    = {1'b0, wr.addr} + FILL_W'(1);
        fill_next = fill_reg;
        if (wr.en && (wr_top > fill_reg))
        begin
            fill_next = wr_top;
        end
        hit_next  = hit_reg;
        zero_next = zero_reg;
        if (rd_en)
        begin
            hit_next  = wr.en && (wr.addr == rd_addr);
            zero_next = {1'b0, rd_addr} >= fill_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            err_mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_q_reg <= err_mem[rd_addr];
            fwd_reg  <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            hit_reg  <= 1'b0;
            zero_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            hit_reg  <= hit_next;
            zero_reg <= zero_next;
        end
    end

    always_comb
    begin
        priority if (hit_reg)
        begin
            rd_data = fwd_reg;
        end
        else if (zero_reg)
        begin
            rd_data = '0;
        end
        else
        begin
            rd_data = rd_q_reg;
        end
    end

    a_fill_covers_write: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |=> fill_reg > {1'b0, $past(wr.addr)})
        else $error("fill mark below a written entry");

    a_fill_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg >= $past(fill_reg))
        else $error("fill mark went backwards");

    a_hit_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rd_en) && hit_reg |-> $past(wr.en))
        else $error("forward hit without a write");

endmodule

`default_nettype wire

### sv/fsd_core.sv
// fsd_core: quantiser and error diffusion, carries the row-local shares and
// builds the line write-back and defers the row end entry to the next cycle
// depends on fsd_pkg
`default_nettype none

module fsd_core
    import fsd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       commit,
    input  wire pix_item_t  item,
    input  wire err_t       below,
    input  wire logic [7:0] threshold,
    output logic            white,
    output line_wr_t        wr
);

    localparam logic signed [V_W-1:0] WHITE_VAL = V_W'(255 * 256);

    err_t               rc_reg;
    err_t               rc_next;
    err_t               blp_reg;
    err_t               blp_next;
    err_t               brp_reg;
    err_t               brp_next;
    logic               pend_valid_reg;
    logic               pend_valid_next;
    logic [LINE_AW-1:0] pend_addr_reg;
    err_t               pend_data_reg;

    logic signed [V_W-1:0] v;
    logic signed [V_W-1:0] thr;
    err_t                  err;
    err_t                  s_right;
    err_t                  s_bl;
    err_t                  s_b;
    err_t                  s_br;
    err_t                  left_val;
    err_t                  blp_new;
    err_t                  brp_new;
    err_t                  corner_val;

    always_comb
    begin
        v     = V_W'($signed({1'b0, item.pixel, 8'd0})) + V_W'(below) + V_W'(rc_reg);
        thr   = V_W'($signed({1'b0, threshold, 8'd0}));
        white = v > thr;
        err   = sat_f(white ? v - WHITE_VAL : v);

        s_right = share_f(err, K_RIGHT);
        s_bl    = share_f(err, K_BELOW_LEFT);
        s_b     = share_f(err, K_BELOW);
        s_br    = share_f(err, K_BELOW_RIGHT);

        // last row leaves zeros behind for the next frame
        left_val   = item.last_row ? '0 : sat_f(V_W'(blp_reg) + V_W'(s_bl));
        blp_new    = item.last_row ? '0 : sat_f(V_W'(brp_reg) + V_W'(s_b));
        brp_new    = item.last_row ? '0 : s_br;
        corner_val = item.last_row ? '0 : blp_new;

        rc_next  = rc_reg;
        blp_next = blp_reg;
        brp_next = brp_reg;
        if (commit)
        begin
            if (item.last_col)
            begin
                rc_next  = '0;
                blp_next = '0;
                brp_next = '0;
            end
            else
            begin
                rc_next  = s_right;
                blp_next = blp_new;
                brp_next = brp_new;
            end
        end

        pend_valid_next = commit && item.last_col && (item.col != '0);

        priority if (commit && (item.col != '0))
        begin
            wr.en   = 1'b1;
            wr.addr = item.col - LINE_AW'(1);
            wr.data = left_val;
        end
        else if (commit && item.last_col)
        begin
            wr.en   = 1'b1;
            wr.addr = item.col;
            wr.data = corner_val;
        end
        else if (pend_valid_reg)
        begin
            wr.en   = 1'b1;
            wr.addr = pend_addr_reg;
            wr.data = pend_data_reg;
        end
        else
        begin
            wr.en   = 1'b0;
            wr.addr = item.col;
            wr.data = corner_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_valid_next)
        begin
            pend_addr_reg <= item.col;
            pend_data_reg <= corner_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rc_reg         <= '0;
            blp_reg        <= '0;
            brp_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            rc_reg         <= rc_next;
            blp_reg        <= blp_next;
            brp_reg        <= brp_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    a_pend_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> !(commit && (item.col != '0)))
        else $error("deferred write collides with a stage write");

    a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.last_col |=> rc_reg == '0 && blp_reg == '0 && brp_reg == '0)
        else $error("row carries not cleared at row end");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> commit || pend_valid_reg)
        else $error("line write without a source");

endmodule

`default_nettype wire

### sv/floyd_steinberg_dither_gray.sv
// floyd_steinberg_dither_gray: top level, raster position, stage handshake
// and output register around the core and the error line buffer
// depends on fsd_pkg, fsd_cfg, fsd_line_mem, fsd_core
//
// grayscale pixels enter in raster order on the s_axis channel (tdata holds
// the 8-bit intensity); each gives one transaction on m_axis: tdata is 0 or
// 255, tlast marks the last pixel of a row, tuser the last pixel of a frame.
// width, height and threshold are set over the apb port while the stream
// is idle; widths beyond the line buffer act as its depth.
// throughput is one pixel per clock while m_axis_tready is high: each
// pixel does one read of the line buffer on acceptance and one write-back
// when it commits, with the row end entry written in the following cycle
// on the same port; inputs pass the working stage and the output register.
// after reset the block takes pixels at once; the line buffer reads as zero
// where it was never written, so no clearing sweep is needed, and the
// position starts at column 0, row 0.
// when the receiver stalls the output register holds its transaction; one
// more pixel enters an empty working stage, then s_axis_tready drops.
`default_nettype none

module floyd_steinberg_dither_gray
    import fsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [7:0]        s_axis_tdata,   // [7:0] gray_pixel
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [7:0]        m_axis_tdata,   // [7:0] out_level
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser    // [0] end_of_frame
);

    cfg_t               cfg;
    logic [LINE_AW-1:0] col_reg;
    logic [LINE_AW-1:0] col_next;
    logic [11:0]        row_reg;
    logic [11:0]        row_next;
    logic [WCMP_W-1:0]  width_ext;
    logic [WCMP_W-1:0]  width_eff;
    logic [LINE_AW-1:0] col_last;
    logic [11:0]        row_last;
    logic [LINE_AW-1:0] col;
    logic [11:0]        row;
    logic               last_col;
    logic               last_row;

    logic      s1_valid_reg;
    logic      s1_valid_next;
    pix_item_t s1_item_reg;
    pix_item_t s1_item_next;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_level_reg;
    logic       eor_reg;
    logic       eof_reg;

    logic     out_en;
    logic     commit;
    logic     accept;
    err_t     below;
    logic     white;
    line_wr_t wr;

    fsd_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign out_en        = !out_valid_reg || m_axis_tready;
    assign commit        = s1_valid_reg && out_en;
    assign s_axis_tready = !s1_valid_reg || out_en;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // effective frame size and clamped raster position
    always_comb
    begin
        width_ext = WCMP_W'(cfg.image_width);
        priority if (width_ext == '0)
        begin
            width_eff = WCMP_W'(1);
        end
        else if (width_ext > WCMP_W'(MAX_LINE_WIDTH))
        begin
            width_eff = WCMP_W'(MAX_LINE_WIDTH);
        end
        else
        begin
            width_eff = width_ext;
        end
        col_last = LINE_AW'(width_eff - WCMP_W'(1));
        row_last = (cfg.image_height == '0) ? '0 : cfg.image_height - 12'd1;

        col      = (col_reg > col_last) ? col_last : col_reg;
        row      = (row_reg > row_last) ? row_last : row_reg;
        last_col = (col == col_last);
        last_row = (row == row_last);

        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row + 12'd1;
            end
            else
            begin
                col_next = col + LINE_AW'(1);
                row_next = row;
            end
        end

        s1_item_next.pixel    = s_axis_tdata;
        s1_item_next.col      = col;
        s1_item_next.last_col = last_col;
        s1_item_next.last_row = last_row;

        s1_valid_next = accept ? 1'b1 : (commit ? 1'b0 : s1_valid_reg);
        out_valid_next = commit ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    fsd_line_mem u_line_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (col),
        .wr      (wr),
        .rd_data (below)
    );

    fsd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .commit    (commit),
        .item      (s1_item_reg),
        .below     (below),
        .threshold (cfg.threshold_level),
        .white     (white),
        .wr        (wr)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= s1_item_next;
        end
        if (commit)
        begin
            out_level_reg <= white ? LEVEL_WHITE : LEVEL_BLACK;
            eor_reg       <= s1_item_reg.last_col;
            eof_reg       <= s1_item_reg.last_col && s1_item_reg.last_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_level_reg;
    assign m_axis_tlast  = eor_reg;
    assign m_axis_tuser  = eof_reg;

endmodule

`default_nettype wire
